// ===== src/iqpm_pkg.sv =====
// Shared constants for the I/Q capture FIFO with power window and clip monitor.
// Field widths, command codes, clip limits and default sizes; no dependencies.
package iqpm_pkg;

  localparam int RAW_W       = 32;
  localparam int SHIFT_BITS  = 8;
  localparam int SMP_W       = RAW_W - SHIFT_BITS;
  localparam int POW_W       = 60;
  localparam int CNT_W       = 32;
  localparam int FILL_OUT_W  = 10;
  localparam int CMD_W       = 2;

  localparam int DEF_RING_DEPTH   = 1024;
  localparam int DEF_POWER_WINDOW = 1024;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RDCLR = 2'd2;

  localparam logic [SMP_W-1:0] CLIP_HI = 24'h7F_FFFF;
  localparam logic [SMP_W-1:0] CLIP_LO = 24'h80_0000;

endpackage

// ===== src/iq_sample_fifo_power_clip_monitor_core.sv =====
// The result strobe follows an accepted beat through the input register, the ring/counter
// stage with squaring and the power window stage.
// Throughput: one beat per cycle; busy stays low, as the ring memory takes one write or one
// read per beat. Reset (rst_n, synchronous, active low) clears pointers, flag, counters and
// the power window; ring contents stay undefined until written. The receiver cannot stall.
// Top level of the I/Q capture FIFO; depends on iqpm_pkg.
module iq_sample_fifo_power_clip_monitor_core
  import iqpm_pkg::*;
#(
  parameter int RING_DEPTH   = DEF_RING_DEPTH,
  parameter int POWER_WINDOW = DEF_POWER_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic signed [RAW_W-1:0] in_raw_left,
  input  logic signed [RAW_W-1:0] in_raw_right,
  output logic                  out_strobe,
  output logic                  out_sample_valid,
  output logic signed [SMP_W-1:0] out_i,
  output logic signed [SMP_W-1:0] out_q,
  output logic                  out_overflow_seen,
  output logic [FILL_OUT_W-1:0] out_fill_count,
  output logic [CNT_W-1:0]      out_overflow_total,
  output logic [CNT_W-1:0]      out_written_total,
  output logic [POW_W-1:0]      out_window_power
);

  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W = PTR_W + 1;
  localparam int POS_W  = $clog2(POWER_WINDOW + 1);
  localparam int SQ_W   = 2 * SMP_W;

  // input register
  logic                  a_vld_r;
  logic [CMD_W-1:0]      a_cmd_r;
  logic [RAW_W-1:0]      a_left_r;
  logic [RAW_W-1:0]      a_right_r;

  // ring and counter state
  logic [PTR_W-1:0]      write_ptr_r, write_ptr_nxt;
  logic [PTR_W-1:0]      read_ptr_r, read_ptr_nxt;
  logic                  ovf_flag_r, ovf_flag_nxt;
  logic [CNT_W-1:0]      ovf_cnt_r, ovf_cnt_nxt;
  logic [CNT_W-1:0]      wr_cnt_r, wr_cnt_nxt;
  logic [SQ_W-1:0]       rd_data_r;
  logic [SQ_W-1:0]       ring_mem [RING_DEPTH];

  // stage B
  logic                  b_vld_r;
  logic                  b_push_r;
  logic                  b_sv_r;
  logic                  b_seen_r;
  logic [FILL_OUT_W-1:0] b_fill_r;
  logic [CNT_W-1:0]      b_ovf_r;
  logic [CNT_W-1:0]      b_wr_r;
  logic [SQ_W-1:0]       b_sq_i_r;
  logic [SQ_W-1:0]       b_sq_q_r;

  // power window state
  logic [POW_W-1:0]      acc_r, acc_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [POW_W-1:0]      last_r, last_nxt;

  // result register
  logic                  out_strobe_r;
  logic                  out_sv_r;
  logic [SMP_W-1:0]      out_i_r;
  logic [SMP_W-1:0]      out_q_r;
  logic                  out_seen_r;
  logic [FILL_OUT_W-1:0] out_fill_r;
  logic [CNT_W-1:0]      out_ovf_r;
  logic [CNT_W-1:0]      out_wr_r;
  logic [POW_W-1:0]      out_pow_r;

  logic                  accept;
  logic signed [SMP_W-1:0] vi, vq;
  logic signed [SQ_W-1:0]  sq_i, sq_q;
  logic [PTR_W-1:0]      wp_inc, rp_inc;
  logic                  ring_full, ring_empty;
  logic                  push_ok, push_drop, pop_ok, rdclr, clip;
  logic [FILL_W-1:0]     fill_nxt;
  logic [31:0]           fill_ext;
  logic [POW_W-1:0]      acc_sum;
  logic [POS_W-1:0]      pos_inc;
  logic                  win_done;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
    if (accept) begin
      a_cmd_r   <= in_cmd;
      a_left_r  <= in_raw_left;
      a_right_r <= in_raw_right;
    end
  end

  assign vi   = a_left_r[RAW_W-1:SHIFT_BITS];
  assign vq   = a_right_r[RAW_W-1:SHIFT_BITS];
  assign sq_i = vi * vi;
  assign sq_q = vq * vq;

  assign wp_inc = (write_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : write_ptr_r + 1'b1;
  assign rp_inc = (read_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : read_ptr_r + 1'b1;
  assign ring_full  = (wp_inc == read_ptr_r);
  assign ring_empty = (write_ptr_r == read_ptr_r);

  assign push_ok   = a_vld_r && (a_cmd_r == CMD_PUSH) && !ring_full;
  assign push_drop = a_vld_r && (a_cmd_r == CMD_PUSH) && ring_full;
  assign pop_ok    = a_vld_r && (a_cmd_r == CMD_POP) && !ring_empty;
  assign rdclr     = a_vld_r && (a_cmd_r == CMD_RDCLR);
  assign clip      = push_ok && (vi == CLIP_HI || vi == CLIP_LO ||
                                 vq == CLIP_HI || vq == CLIP_LO);

  always_comb begin
    write_ptr_nxt = push_ok ? wp_inc : write_ptr_r;
    read_ptr_nxt  = pop_ok ? rp_inc : read_ptr_r;
    wr_cnt_nxt    = push_ok ? wr_cnt_r + 1'b1 : wr_cnt_r;
    ovf_cnt_nxt   = (push_drop || clip) ? ovf_cnt_r + 1'b1 : ovf_cnt_r;
    priority if (rdclr) begin
      ovf_flag_nxt = 1'b0;
    end else if (push_drop || clip) begin
      ovf_flag_nxt = 1'b1;
    end else begin
      ovf_flag_nxt = ovf_flag_r;
    end
    fill_nxt = FILL_W'({1'b0, write_ptr_nxt}) - FILL_W'({1'b0, read_ptr_nxt})
             + ((write_ptr_nxt < read_ptr_nxt) ? FILL_W'(RING_DEPTH) : '0);
    fill_ext = 32'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ring_mem[write_ptr_r] <= {vi, vq};
    end
    if (pop_ok) begin
      rd_data_r <= ring_mem[read_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_ptr_r <= '0;
      read_ptr_r  <= '0;
      ovf_flag_r  <= 1'b0;
      ovf_cnt_r   <= '0;
      wr_cnt_r    <= '0;
      b_vld_r     <= 1'b0;
      b_push_r    <= 1'b0;
    end else begin
      write_ptr_r <= write_ptr_nxt;
      read_ptr_r  <= read_ptr_nxt;
      ovf_flag_r  <= ovf_flag_nxt;
      ovf_cnt_r   <= ovf_cnt_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      b_vld_r     <= a_vld_r;
      b_push_r    <= push_ok;
    end
    b_sv_r   <= pop_ok;
    b_seen_r <= rdclr && ovf_flag_r;
    b_fill_r <= fill_ext[FILL_OUT_W-1:0];
    b_ovf_r  <= ovf_cnt_nxt;
    b_wr_r   <= wr_cnt_nxt;
    b_sq_i_r <= sq_i;
    b_sq_q_r <= sq_q;
  end

  assign acc_sum  = acc_r + POW_W'(b_sq_i_r) + POW_W'(b_sq_q_r);
  assign pos_inc  = pos_r + 1'b1;
  assign win_done = (pos_inc == POS_W'(POWER_WINDOW));

  always_comb begin
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    last_nxt = last_r;
    if (b_push_r) begin
      if (win_done) begin
        acc_nxt  = '0;
        pos_nxt  = '0;
        last_nxt = acc_sum;
      end else begin
        acc_nxt  = acc_sum;
        pos_nxt  = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      pos_r        <= '0;
      last_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      acc_r        <= acc_nxt;
      pos_r        <= pos_nxt;
      last_r       <= last_nxt;
      out_strobe_r <= b_vld_r;
    end
    out_sv_r   <= b_sv_r;
    out_i_r    <= b_sv_r ? rd_data_r[SQ_W-1:SMP_W] : '0;
    out_q_r    <= b_sv_r ? rd_data_r[SMP_W-1:0] : '0;
    out_seen_r <= b_seen_r;
    out_fill_r <= b_fill_r;
    out_ovf_r  <= b_ovf_r;
    out_wr_r   <= b_wr_r;
    out_pow_r  <= last_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_sample_valid   = out_sv_r;
  assign out_i              = out_i_r;
  assign out_q              = out_q_r;
  assign out_overflow_seen  = out_seen_r;
  assign out_fill_count     = out_fill_r;
  assign out_overflow_total = out_ovf_r;
  assign out_written_total  = out_wr_r;
  assign out_window_power   = out_pow_r;

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> (write_ptr_r != read_ptr_r))
    else $error("ring empty after stored push");

  a_pop_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok |=> !ring_full)
    else $error("ring full after pop");

  a_strobe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(accept, 3))
    else $error("result beat without accepted command");

  a_seen_only_rdclr: assert property (@(posedge clk) disable iff (!rst_n)
    b_seen_r |-> $past(a_cmd_r == CMD_RDCLR))
    else $error("overflow seen on other command");

endmodule

// ===== bench/tb_iq_sample_fifo_power_clip_monitor_core.sv =====
// Testbench for iq_sample_fifo_power_clip_monitor_core: directed table, then random beats
// that fill the ring to full and drain it, each checked against a local predictor or, for
// typed rows, the table entry. Depends on iqpm_pkg and the core RTL only.
module tb_iq_sample_fifo_power_clip_monitor_core;
  import iqpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int DIR_N       = 22;
  localparam int PHASE_BEATS = 400;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic                  sample_valid;
    logic signed [SMP_W-1:0] i;
    logic signed [SMP_W-1:0] q;
    logic                  seen;
    logic [FILL_OUT_W-1:0] fill;
    logic [CNT_W-1:0]      ovf_total;
    logic [CNT_W-1:0]      wr_total;
    logic [POW_W-1:0]      power;
  } fifo_status_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [RAW_W-1:0] raw_l;
    logic [RAW_W-1:0] raw_r;
    logic             typed;
    fifo_status_t     want;
  } dir_row_t;

  localparam fifo_status_t NO_WANT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_cmd = CMD_PUSH;
  logic signed [RAW_W-1:0] in_raw_left = '0;
  logic signed [RAW_W-1:0] in_raw_right = '0;
  logic out_strobe;
  logic out_sample_valid;
  logic signed [SMP_W-1:0] out_i;
  logic signed [SMP_W-1:0] out_q;
  logic out_overflow_seen;
  logic [FILL_OUT_W-1:0] out_fill_count;
  logic [CNT_W-1:0] out_overflow_total;
  logic [CNT_W-1:0] out_written_total;
  logic [POW_W-1:0] out_window_power;

  iq_sample_fifo_power_clip_monitor_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_raw_left       (in_raw_left),
    .in_raw_right      (in_raw_right),
    .out_strobe        (out_strobe),
    .out_sample_valid  (out_sample_valid),
    .out_i             (out_i),
    .out_q             (out_q),
    .out_overflow_seen (out_overflow_seen),
    .out_fill_count    (out_fill_count),
    .out_overflow_total(out_overflow_total),
    .out_written_total (out_written_total),
    .out_window_power  (out_window_power)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [SMP_W-1:0] ring_i [DEF_RING_DEPTH];
  logic signed [SMP_W-1:0] ring_q [DEF_RING_DEPTH];
  int                wr_ptr = 0;
  int                rd_ptr = 0;
  bit                ovf_flag = 1'b0;
  logic [CNT_W-1:0]  ovf_count = '0;
  logic [CNT_W-1:0]  wr_count = '0;
  logic [POW_W-1:0]  pow_acc = '0;
  logic [POW_W-1:0]  pow_last = '0;
  int                win_pos = 0;

  fifo_status_t pending_status[$];
  int mismatches = 0;
  int stall_cycles = 0;

  function automatic int ring_fill();
    return (wr_ptr - rd_ptr + DEF_RING_DEPTH) % DEF_RING_DEPTH;
  endfunction

  function automatic fifo_status_t predict_status(input logic [CMD_W-1:0] c,
                                                  input logic [RAW_W-1:0] l,
                                                  input logic [RAW_W-1:0] r);
    fifo_status_t s;
    logic signed [SMP_W-1:0] vi;
    logic signed [SMP_W-1:0] vq;
    longint sq;
    int nxt;
    s = '0;
    vi = l[RAW_W-1:SHIFT_BITS];
    vq = r[RAW_W-1:SHIFT_BITS];
    case (c)
      CMD_PUSH: begin
        nxt = (wr_ptr + 1) % DEF_RING_DEPTH;
        if (nxt == rd_ptr) begin
          ovf_flag = 1'b1;
          ovf_count++;
        end else begin
          ring_i[wr_ptr] = vi;
          ring_q[wr_ptr] = vq;
          wr_ptr = nxt;
          wr_count++;
          sq = longint'(vi) * longint'(vi) + longint'(vq) * longint'(vq);
          pow_acc = pow_acc + POW_W'(sq);
          win_pos++;
          if (win_pos >= DEF_POWER_WINDOW) begin
            pow_last = pow_acc;
            pow_acc = '0;
            win_pos = 0;
          end
          if (vi == CLIP_HI || vi == CLIP_LO || vq == CLIP_HI || vq == CLIP_LO) begin
            ovf_flag = 1'b1;
            ovf_count++;
          end
        end
      end
      CMD_POP: begin
        if (rd_ptr != wr_ptr) begin
          s.sample_valid = 1'b1;
          s.i = ring_i[rd_ptr];
          s.q = ring_q[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEF_RING_DEPTH;
        end
      end
      CMD_RDCLR: begin
        s.seen = ovf_flag;
        ovf_flag = 1'b0;
      end
      default: ;
    endcase
    s.fill = FILL_OUT_W'(ring_fill());
    s.ovf_total = ovf_count;
    s.wr_total = wr_count;
    s.power = pow_last;
    return s;
  endfunction

  function automatic string show(input fifo_status_t s);
    return $sformatf("valid=%0b i=%0d q=%0d seen=%0b fill=%0d ovf=%0d wr=%0d pow=%0d",
                     s.sample_valid, s.i, s.q, s.seen, s.fill, s.ovf_total, s.wr_total,
                     s.power);
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw();
    logic [RAW_W-1:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: v[RAW_W-1:SHIFT_BITS] = CLIP_HI;
      1: v[RAW_W-1:SHIFT_BITS] = CLIP_LO;
      2: v[RAW_W-1:SHIFT_BITS] = CLIP_HI - 1'b1;
      3: v[RAW_W-1:SHIFT_BITS] = CLIP_LO + 1'b1;
      4: v[RAW_W-1:SHIFT_BITS+8] = {(RAW_W-SHIFT_BITS-8){v[SHIFT_BITS+7]}};
      default: ;
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  task automatic send_beat(input logic [CMD_W-1:0] c, input logic [RAW_W-1:0] l,
                           input logic [RAW_W-1:0] r, input logic typed,
                           input fifo_status_t want);
    fifo_status_t p;
    start <= 1'b1;
    in_cmd <= c;
    in_raw_left <= l;
    in_raw_right <= r;
    do @(posedge clk); while (busy);
    p = predict_status(c, l, r);
    pending_status.push_back(typed ? want : p);
  endtask

  task automatic pause_sender(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  always @(posedge clk) begin
    fifo_status_t got;
    fifo_status_t want;
    if (rst_n && out_strobe) begin
      got = '{out_sample_valid, out_i, out_q, out_overflow_seen, out_fill_count,
              out_overflow_total, out_written_total, out_window_power};
      if (pending_status.size() == 0) begin
        flag_mismatch({"unexpected beat: ", show(got)});
      end else begin
        want = pending_status.pop_front();
        if (got !== want) flag_mismatch({"expected ", show(want), " got ", show(got)});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [DIR_N];
    logic [CMD_W-1:0] c;
    int roll;
    int pct;
    int k;
    int full_beats;
    bit draining;

    dir_rows = '{
      '{CMD_POP,   32'h0, 32'h0, 1'b1, '{1'b0, 24'h0, 24'h0, 1'b0, 10'd0, 32'd0, 32'd0, 60'd0}},
      '{CMD_RDCLR, 32'h0, 32'h0, 1'b1, '{1'b0, 24'h0, 24'h0, 1'b0, 10'd0, 32'd0, 32'd0, 60'd0}},
      '{CMD_NONE,  32'h0, 32'h0, 1'b1, '{1'b0, 24'h0, 24'h0, 1'b0, 10'd0, 32'd0, 32'd0, 60'd0}},
      '{CMD_PUSH, 32'h7FFFFFFF, 32'h80000000, 1'b1,
        '{1'b0, 24'h0, 24'h0, 1'b0, 10'd1, 32'd1, 32'd1, 60'd0}},
      '{CMD_PUSH, 32'h7FFFFE00, 32'h80000100, 1'b1,
        '{1'b0, 24'h0, 24'h0, 1'b0, 10'd2, 32'd1, 32'd2, 60'd0}},
      '{CMD_RDCLR, 32'h0, 32'h0, 1'b1, '{1'b0, 24'h0, 24'h0, 1'b1, 10'd2, 32'd1, 32'd2, 60'd0}},
      '{CMD_RDCLR, 32'h0, 32'h0, 1'b1, '{1'b0, 24'h0, 24'h0, 1'b0, 10'd2, 32'd1, 32'd2, 60'd0}},
      '{CMD_POP, 32'h0, 32'h0, 1'b1,
        '{1'b1, 24'h7FFFFF, 24'h800000, 1'b0, 10'd1, 32'd1, 32'd2, 60'd0}},
      '{CMD_POP, 32'h0, 32'h0, 1'b1,
        '{1'b1, 24'h7FFFFE, 24'h800001, 1'b0, 10'd0, 32'd1, 32'd2, 60'd0}},
      '{CMD_POP,   32'h0, 32'h0, 1'b1, '{1'b0, 24'h0, 24'h0, 1'b0, 10'd0, 32'd1, 32'd2, 60'd0}},
      '{CMD_PUSH,  32'h000000FF, 32'hFFFFFFFF, 1'b0, NO_WANT},
      '{CMD_PUSH,  32'hFFFFFF00, 32'h00000100, 1'b0, NO_WANT},
      '{CMD_PUSH,  32'h7FFFFF7F, 32'h00000000, 1'b0, NO_WANT},
      '{CMD_PUSH,  32'h12345678, 32'h87654321, 1'b0, NO_WANT},
      '{CMD_NONE,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_WANT},
      '{CMD_RDCLR, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b0, NO_WANT},
      '{CMD_POP,   32'h0, 32'h0, 1'b0, NO_WANT},
      '{CMD_POP,   32'h0, 32'h0, 1'b0, NO_WANT},
      '{CMD_PUSH,  32'h80000000, 32'h800000FF, 1'b0, NO_WANT},
      '{CMD_POP,   32'h0, 32'h0, 1'b0, NO_WANT},
      '{CMD_POP,   32'h0, 32'h0, 1'b0, NO_WANT},
      '{CMD_POP,   32'h0, 32'h0, 1'b0, NO_WANT}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[n])
      send_beat(dir_rows[n].cmd, dir_rows[n].raw_l, dir_rows[n].raw_r, dir_rows[n].typed,
                dir_rows[n].want);
    drain_results();

    // fill toward full, hold there a while, then drain
    full_beats = 0;
    draining = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 6 : (ph == 1) ? 70 : 0;
      k = 0;
      while (k < PHASE_BEATS) begin
        pause_sender(pct);
        roll = $urandom_range(99);
        if (!draining)
          c = (roll < 95) ? CMD_PUSH : (roll < 97) ? CMD_POP : (roll < 99) ? CMD_RDCLR : CMD_NONE;
        else
          c = (roll < 15) ? CMD_PUSH : (roll < 85) ? CMD_POP : (roll < 95) ? CMD_RDCLR : CMD_NONE;
        send_beat(c, rand_raw(), rand_raw(), 1'b0, NO_WANT);
        if (ring_fill() == DEF_RING_DEPTH - 1) full_beats++;
        if (full_beats >= 24) draining = 1'b1;
        if (c != CMD_NONE) k++;
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
